>>> rtl/tsg_pkg.sv
// Shared widths, codes and controller/datapath interface types for the tilt sand grid.
package tsg_pkg;

   // Grid geometry; coordinates and the image keep a fixed stride of eight.
   localparam int GRID_SIZE  = 8;
   localparam int COORD_W    = 3;
   localparam int IMAGE_W    = 64;
   localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;

   // Field widths.
   localparam int TILT_W   = 8;
   localparam int DIR_W    = 3;
   localparam int TICK_W   = 16;
   localparam int PERIOD_W = 10;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 72;

   // Step counter covers both the remainder steps and the cell sweep.
   localparam int CNT_W = ($clog2(CELL_COUNT) > $clog2(TICK_W)) ?
                          $clog2(CELL_COUNT) : $clog2(TICK_W);

   // Register write port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_DROP_COL    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DROP_ROW    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DROP_PERIOD = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RUN_LENGTH  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic mod_step;
      logic drop;
      logic sweep_step;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mod_last;
      logic sweep_last;
   } status_type;

endpackage

>>> rtl/tsg_ctrl.sv
// Sequencing state machine for one tick: remainder, drop, sweep and result handoff.
module tsg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output tsg_pkg::cmd_type    cmd,
   input  tsg_pkg::status_type status
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MOD    = 5'b00010,
      ST_DROP   = 5'b00100,
      ST_SWEEP  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state, commands and result valid.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_MOD;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_last) begin
               state_in = ST_DROP;
            end
         end
         ST_DROP: begin
            cmd.drop = 1'b1;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/tsg_datapath.sv
// Datapath: direction pick, drop schedule remainder, grid sweep and registers.
module tsg_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tsg_pkg::cmd_type                       cmd,
   output tsg_pkg::status_type                    status,
   input  logic [tsg_pkg::REQ_DATA_W-1:0]         req_tdata,
   input  logic                                   csr_write,
   input  logic [tsg_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [tsg_pkg::CSR_DATA_W-1:0]         csr_data,
   output logic [tsg_pkg::RSP_DATA_W-1:0]         rsp_tdata
);

   localparam logic [tsg_pkg::COORD_W-1:0] LastC  = tsg_pkg::COORD_W'(tsg_pkg::GRID_SIZE - 1);
   localparam logic [tsg_pkg::COORD_W:0]   SizeW  = (tsg_pkg::COORD_W + 1)'(tsg_pkg::GRID_SIZE);
   localparam logic [tsg_pkg::COORD_W-1:0] ZeroC  = '0;
   localparam logic [tsg_pkg::COORD_W-1:0] OneC   = tsg_pkg::COORD_W'(1);

   // Direction codes, counting from +x toward +y.
   localparam logic [2:0] DIR_PX   = 3'd0;
   localparam logic [2:0] DIR_PXPY = 3'd1;
   localparam logic [2:0] DIR_PY   = 3'd2;
   localparam logic [2:0] DIR_MXPY = 3'd3;
   localparam logic [2:0] DIR_MX   = 3'd4;
   localparam logic [2:0] DIR_MXMY = 3'd5;
   localparam logic [2:0] DIR_MY   = 3'd6;
   localparam logic [2:0] DIR_PXMY = 3'd7;

   // Unit step along x of a direction, as a 4-bit two's complement value.
   function automatic logic [3:0] step_dx(input logic [2:0] d);
      logic [3:0] s;
      unique case (d)
         DIR_PX, DIR_PXPY, DIR_PXMY: s = 4'b0001;
         DIR_MX, DIR_MXPY, DIR_MXMY: s = 4'b1111;
         default:                    s = 4'b0000;
      endcase
      return s;
   endfunction

   // Unit step along y of a direction.
   function automatic logic [3:0] step_dy(input logic [2:0] d);
      logic [3:0] s;
      unique case (d)
         DIR_PY, DIR_PXPY, DIR_MXPY: s = 4'b0001;
         DIR_MY, DIR_MXMY, DIR_PXMY: s = 4'b1111;
         default:                    s = 4'b0000;
      endcase
      return s;
   endfunction

   // One term of the dot product: +v, -v or zero.
   function automatic logic signed [9:0] dot_term(input logic [7:0] v, input logic [3:0] s);
      logic signed [9:0] e;
      logic signed [9:0] r;
      e = {{2{v[7]}}, v};
      if (s == 4'b0001) begin
         r = e;
      end else if (s == 4'b1111) begin
         r = -e;
      end else begin
         r = '0;
      end
      return r;
   endfunction

   // First cell of the sweep: highest dot value, lowest x.
   function automatic logic [5:0] sweep_start(input logic [2:0] d);
      logic [5:0] c;
      unique case (d)
         DIR_PX:   c = {LastC, ZeroC};
         DIR_PXPY: c = {LastC, LastC};
         DIR_PY:   c = {ZeroC, LastC};
         DIR_MXPY: c = {ZeroC, LastC};
         DIR_MX:   c = {ZeroC, ZeroC};
         DIR_MXMY: c = {ZeroC, ZeroC};
         DIR_MY:   c = {ZeroC, ZeroC};
         DIR_PXMY: c = {LastC, ZeroC};
         default:  c = {ZeroC, ZeroC};
      endcase
      return c;
   endfunction

   // Next cell: x (or y for +-x) ascending in one dot value, then the next lower value.
   function automatic logic [5:0] sweep_next(input logic [2:0] d,
                                             input logic [2:0] x,
                                             input logic [2:0] y);
      logic [5:0] c;
      unique case (d)
         DIR_PX: begin
            c = (y != LastC) ? {x, y + OneC} : {x - OneC, ZeroC};
         end
         DIR_MX: begin
            c = (y != LastC) ? {x, y + OneC} : {x + OneC, ZeroC};
         end
         DIR_PY: begin
            c = (x != LastC) ? {x + OneC, y} : {ZeroC, y - OneC};
         end
         DIR_MY: begin
            c = (x != LastC) ? {x + OneC, y} : {ZeroC, y + OneC};
         end
         DIR_PXPY: begin
            if (y == ZeroC) begin
               c = {ZeroC, x - OneC};
            end else if (x == LastC) begin
               c = {y - OneC, LastC};
            end else begin
               c = {x + OneC, y - OneC};
            end
         end
         DIR_MXPY: begin
            if (x == LastC) begin
               c = {LastC - y + OneC, ZeroC};
            end else if (y == LastC) begin
               c = {ZeroC, LastC - OneC - x};
            end else begin
               c = {x + OneC, y + OneC};
            end
         end
         DIR_MXMY: begin
            if (x == LastC) begin
               c = {y + OneC, LastC};
            end else if (y == ZeroC) begin
               c = {ZeroC, x + OneC};
            end else begin
               c = {x + OneC, y - OneC};
            end
         end
         DIR_PXMY: begin
            if (y == LastC) begin
               c = {ZeroC, LastC - x + OneC};
            end else if (x == LastC) begin
               c = {LastC - OneC - y, ZeroC};
            end else begin
               c = {x + OneC, y + OneC};
            end
         end
         default: begin
            c = {x, y};
         end
      endcase
      return c;
   endfunction

   // Configuration registers.
   logic [tsg_pkg::COORD_W-1:0]  drop_col_ff;
   logic [tsg_pkg::COORD_W-1:0]  drop_row_ff;
   logic [tsg_pkg::PERIOD_W-1:0] drop_period_ff;
   logic [tsg_pkg::TICK_W-1:0]   run_length_ff;

   // Persistent state and per-tick working registers.
   logic [tsg_pkg::IMAGE_W-1:0]  grid_ff, grid_in;
   logic [tsg_pkg::TICK_W-1:0]   tick_ff, tick_in;
   logic [tsg_pkg::IMAGE_W-1:0]  order_ff;
   logic [tsg_pkg::DIR_W-1:0]    dir_ff;
   logic [tsg_pkg::PERIOD_W-1:0] rem_ff, rem_in;
   logic [tsg_pkg::TICK_W-1:0]   div_ff;
   logic [tsg_pkg::CNT_W-1:0]    cnt_ff;
   logic [tsg_pkg::COORD_W-1:0]  cur_x_ff, cur_y_ff;
   logic [tsg_pkg::IMAGE_W-1:0]  rsp_grid_ff;
   logic [tsg_pkg::DIR_W-1:0]    rsp_dir_ff;

   logic [tsg_pkg::TILT_W-1:0]   tilt_x, tilt_y;
   logic [tsg_pkg::DIR_W-1:0]    best_dir;
   logic [tsg_pkg::PERIOD_W:0]   rem_shift;
   logic                         drop_hit;
   logic                         drop_in_grid;
   logic [tsg_pkg::IMAGE_W-1:0]  moved_grid;
   logic [tsg_pkg::TICK_W:0]     tick_next;
   logic [tsg_pkg::TICK_W:0]     tick_limit;
   logic [5:0]                   start_cell, next_cell;

   assign tilt_x = req_tdata[7:0];
   assign tilt_y = req_tdata[15:8];

   // Gravity direction: first of the eight vectors with the largest dot product.
   always_comb begin
      logic signed [9:0] dot;
      logic signed [9:0] best;
      best     = dot_term(tilt_x, step_dx(DIR_PX)) + dot_term(tilt_y, step_dy(DIR_PX));
      best_dir = DIR_PX;
      for (int i = 1; i < 8; i++) begin
         dot = dot_term(tilt_x, step_dx(3'(i))) + dot_term(tilt_y, step_dy(3'(i)));
         if (dot > best) begin
            best     = dot;
            best_dir = 3'(i);
         end
      end
   end

   // One restoring step of tick_count modulo drop_period.
   always_comb begin
      rem_shift = {rem_ff, div_ff[tsg_pkg::TICK_W-1]};
      if (rem_shift >= {1'b0, drop_period_ff}) begin
         rem_shift = rem_shift - {1'b0, drop_period_ff};
      end
      rem_in = rem_shift[tsg_pkg::PERIOD_W-1:0];
   end

   // Drop decision for this tick.
   assign drop_hit     = (drop_period_ff == '0) ? (tick_ff == '0) : (rem_ff == '0);
   assign drop_in_grid = ({1'b0, drop_col_ff} < SizeW) && ({1'b0, drop_row_ff} < SizeW);

   // Move of the grain at the current sweep cell.
   always_comb begin
      logic [5:0]       cur;
      logic             left_first;
      logic [2:0]       tries [3];
      logic [3:0]       nx;
      logic [3:0]       ny;
      logic             done;
      cur        = {cur_x_ff, cur_y_ff};
      left_first = order_ff[cur];
      tries[0]   = dir_ff;
      tries[1]   = left_first ? (dir_ff - 3'd1) : (dir_ff + 3'd1);
      tries[2]   = left_first ? (dir_ff + 3'd1) : (dir_ff - 3'd1);
      moved_grid = grid_ff;
      done       = !grid_ff[cur];
      for (int k = 0; k < 3; k++) begin
         nx = {1'b0, cur_x_ff} + step_dx(tries[k]);
         ny = {1'b0, cur_y_ff} + step_dy(tries[k]);
         if (!done && (nx < SizeW) && (ny < SizeW) && !grid_ff[{nx[2:0], ny[2:0]}]) begin
            moved_grid[{nx[2:0], ny[2:0]}] = 1'b1;
            moved_grid[cur]                = 1'b0;
            done                           = 1'b1;
         end
      end
   end

   // Grid next value.
   always_comb begin
      grid_in = grid_ff;
      if (cmd.start && (tick_ff == '0)) begin
         grid_in = '0;
      end
      if (cmd.drop && drop_hit && drop_in_grid) begin
         grid_in[{drop_col_ff, drop_row_ff}] = 1'b1;
      end
      if (cmd.sweep_step) begin
         grid_in = moved_grid;
      end
   end

   // Tick count advance, wrapping at the run length.
   always_comb begin
      tick_next  = {1'b0, tick_ff} + (tsg_pkg::TICK_W + 1)'(1);
      tick_limit = (run_length_ff == '0) ? {1'b1, {tsg_pkg::TICK_W{1'b0}}} :
                                            {1'b0, run_length_ff};
      tick_in    = (tick_next >= tick_limit) ? '0 : tick_next[tsg_pkg::TICK_W-1:0];
   end

   assign start_cell = sweep_start(dir_ff);
   assign next_cell  = sweep_next(dir_ff, cur_x_ff, cur_y_ff);

   // Step counter terminals.
   assign status.mod_last   = (cnt_ff == tsg_pkg::CNT_W'(tsg_pkg::TICK_W - 1));
   assign status.sweep_last = (cnt_ff == tsg_pkg::CNT_W'(tsg_pkg::CELL_COUNT - 1));

   // Configuration registers and persistent state.
   always_ff @(posedge clock) begin
      if (reset) begin
         drop_col_ff    <= tsg_pkg::COORD_W'(3);
         drop_row_ff    <= tsg_pkg::COORD_W'(7);
         drop_period_ff <= tsg_pkg::PERIOD_W'(10);
         run_length_ff  <= tsg_pkg::TICK_W'(10000);
         grid_ff        <= '0;
         tick_ff        <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               tsg_pkg::CSR_DROP_COL:    drop_col_ff    <= csr_data[tsg_pkg::COORD_W-1:0];
               tsg_pkg::CSR_DROP_ROW:    drop_row_ff    <= csr_data[tsg_pkg::COORD_W-1:0];
               tsg_pkg::CSR_DROP_PERIOD: drop_period_ff <= csr_data[tsg_pkg::PERIOD_W-1:0];
               tsg_pkg::CSR_RUN_LENGTH:  run_length_ff  <= csr_data[tsg_pkg::TICK_W-1:0];
               default: ;
            endcase
         end
         grid_ff <= grid_in;
         if (cmd.finish) begin
            tick_ff <= tick_in;
         end
      end
   end

   // Working registers of one tick.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         order_ff <= req_tdata[tsg_pkg::REQ_DATA_W-1:16];
         dir_ff   <= best_dir;
         rem_ff   <= '0;
         div_ff   <= tick_ff;
         cnt_ff   <= '0;
      end else if (cmd.mod_step) begin
         rem_ff <= rem_in;
         div_ff <= {div_ff[tsg_pkg::TICK_W-2:0], 1'b0};
         cnt_ff <= cnt_ff + tsg_pkg::CNT_W'(1);
      end else if (cmd.drop) begin
         cnt_ff   <= '0;
         cur_x_ff <= start_cell[5:3];
         cur_y_ff <= start_cell[2:0];
      end else if (cmd.sweep_step) begin
         cnt_ff   <= cnt_ff + tsg_pkg::CNT_W'(1);
         cur_x_ff <= next_cell[5:3];
         cur_y_ff <= next_cell[2:0];
      end
      if (cmd.finish) begin
         rsp_grid_ff <= grid_ff;
         rsp_dir_ff  <= dir_ff;
      end
   end

   assign rsp_tdata = {(tsg_pkg::RSP_DATA_W - tsg_pkg::IMAGE_W - tsg_pkg::DIR_W)'(0),
                       rsp_dir_ff, rsp_grid_ff};

endmodule

>>> rtl/tilt_sand_grid_step.sv
// Top level of the tilt-driven sand grid: one request per tick, one result per request.
// A new request is taken only in idle, once the last result is in the output register.
// Each tick runs a 16-step remainder unit for the drop schedule, then the sweep that
// moves the grain of one cell per cycle over all 64 cells.
// Synchronous reset empties the grid, zeroes the tick count and loads register defaults.
module tilt_sand_grid_step (
   input  logic                                clock,
   input  logic                                reset,
   // Request: tilt_x [7:0], tilt_y [15:8], order_bits [79:16].
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tsg_pkg::REQ_DATA_W-1:0]      req_tdata,
   // Result: grid_image [63:0], gravity_dir [66:64], zero fill [71:67].
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tsg_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Register writes.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tsg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tsg_pkg::CSR_DATA_W-1:0]      csr_data
);

   tsg_pkg::cmd_type    cmd;
   tsg_pkg::status_type status;

   // Registers are always writable.
   assign csr_ready = 1'b1;

   // Sequencing.
   tsg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // Datapath.
   tsg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

endmodule
